[src/aar_pkg.sv]
package aar_pkg;

	localparam int TRIG_STEPS_DEF = 30;
	localparam int ROOT_STEPS_DEF = 32;
	localparam int DIV_STEPS = 32;
	localparam int MOD_STEPS = 14;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [35:0] TWO_PI_Q32 = 36'd26986075409;
	localparam logic [35:0] PI_Q32 = 36'd13493037705;
	localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;

	function automatic int norm_latency(int rs);
		return rs + 6 + DIV_STEPS + 1;
	endfunction

	function automatic int trig_latency(int ts);
		return ts + MOD_STEPS + 3;
	endfunction

	localparam int MATRIX_LATENCY = 3;

	function automatic logic signed [36:0] atan_q32(logic [4:0] idx);
		logic signed [36:0] r;
		case (idx)
			5'd0: r = 37'sd3373259426;
			5'd1: r = 37'sd1991351318;
			5'd2: r = 37'sd1052175346;
			5'd3: r = 37'sd534100635;
			5'd4: r = 37'sd268086748;
			5'd5: r = 37'sd134174063;
			5'd6: r = 37'sd67103403;
			5'd7: r = 37'sd33553749;
			5'd8: r = 37'sd16777131;
			5'd9: r = 37'sd8388597;
			5'd10: r = 37'sd4194303;
			5'd11: r = 37'sd2097152;
			5'd12: r = 37'sd1048576;
			5'd13: r = 37'sd524288;
			5'd14: r = 37'sd262144;
			5'd15: r = 37'sd131072;
			5'd16: r = 37'sd65536;
			5'd17: r = 37'sd32768;
			5'd18: r = 37'sd16384;
			5'd19: r = 37'sd8192;
			5'd20: r = 37'sd4096;
			5'd21: r = 37'sd2048;
			5'd22: r = 37'sd1024;
			5'd23: r = 37'sd512;
			5'd24: r = 37'sd256;
			5'd25: r = 37'sd128;
			5'd26: r = 37'sd64;
			5'd27: r = 37'sd32;
			5'd28: r = 37'sd16;
			5'd29: r = 37'sd8;
			5'd30: r = 37'sd4;
			5'd31: r = 37'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 by Q30 product, rounded to nearest with ties upwards.
	function automatic logic signed [33:0] mul_q30(logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd536870912;
		return 34'(t >>> 30);
	endfunction

	function automatic logic signed [31:0] clamp_unit(logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'(ONE_Q30))
			r = ONE_Q30;
		else if (v < -36'(ONE_Q30))
			r = -ONE_Q30;
		else
			r = 32'(v);
		return r;
	endfunction

	// Left shift that brings the largest magnitude to bit 30 or above.
	function automatic logic [4:0] norm_shift(logic [31:0] v);
		logic [4:0] pos;
		pos = '0;
		for (int p = 0; p < 32; p++)
			if (v[p])
				pos = 5'(p);
		return (pos >= 5'd30) ? 5'd0 : 5'(5'd30 - pos);
	endfunction

endpackage

[src/aar_delay.sv]
module aar_delay import aar_pkg::*; #(
	parameter int W = 64,
	parameter int DEPTH = 8
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++)
			tap_q[i] <= tap_q[i-1];
	end

	assign q = tap_q[DEPTH-1];

endmodule

[src/aar_norm.sv]
module aar_norm import aar_pkg::*; #(
	parameter int ROOT_STEPS = ROOT_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic               out_valid,
	output logic               out_zero,
	output logic signed [31:0] u [3]
);

	localparam int RW = ROOT_STEPS + 3;
	localparam int DW = ROOT_STEPS + 1;
	localparam int NW = ROOT_STEPS + 30;

	logic [31:0] mag_s1 [3];
	logic [2:0]  neg_s1;
	logic        zero_s1, v_s1;
	logic [31:0] mag_s2 [3];
	logic [31:0] big_s2;
	logic [2:0]  neg_s2;
	logic        zero_s2, v_s2;
	logic [31:0] mag_s3 [3];
	logic [4:0]  k_s3;
	logic [2:0]  neg_s3;
	logic        zero_s3, v_s3;
	logic [31:0] sh_s4 [3];
	logic [2:0]  neg_s4;
	logic        zero_s4, v_s4;
	logic [63:0] sq_s5 [3];
	logic [31:0] sh_s5 [3];
	logic [2:0]  neg_s5;
	logic        zero_s5, v_s5;

	// Square-root stages; element 0 is the sum register.
	logic [63:0]           nn_s   [ROOT_STEPS+1];
	logic [RW-1:0]         rm_s   [ROOT_STEPS+1];
	logic [ROOT_STEPS-1:0] rt_s   [ROOT_STEPS+1];
	logic [31:0]           shr_s  [ROOT_STEPS+1][3];
	logic [2:0]            negr_s [ROOT_STEPS+1];
	logic                  zr_s   [ROOT_STEPS+1];
	logic                  vr_s   [ROOT_STEPS+1];

	// Divider stages; element 0 is formed from the last root stage.
	logic [DW-1:0]         dr_s   [DIV_STEPS+1][3];
	logic [31:0]           dl_s   [DIV_STEPS+1][3];
	logic [31:0]           dq_s   [DIV_STEPS+1][3];
	logic [ROOT_STEPS-1:0] dd_s   [DIV_STEPS+1];
	logic [2:0]            negd_s [DIV_STEPS+1];
	logic                  zd_s   [DIV_STEPS+1];
	logic                  vd_s   [DIV_STEPS+1];

	logic [NW-1:0] num [3];
	logic signed [31:0] u_q [3];
	logic zero_q, valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			vr_s[0] <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vr_s[0] <= v_s5;
			valid_q <= vd_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		mag_s1[0] <= axis_x[31] ? 32'(-axis_x) : axis_x;
		mag_s1[1] <= axis_y[31] ? 32'(-axis_y) : axis_y;
		mag_s1[2] <= axis_z[31] ? 32'(-axis_z) : axis_z;
		neg_s1 <= {axis_z[31], axis_y[31], axis_x[31]};
		zero_s1 <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);

		mag_s2 <= mag_s1;
		big_s2 <= (mag_s1[0] >= mag_s1[1])
			? ((mag_s1[0] >= mag_s1[2]) ? mag_s1[0] : mag_s1[2])
			: ((mag_s1[1] >= mag_s1[2]) ? mag_s1[1] : mag_s1[2]);
		neg_s2 <= neg_s1;
		zero_s2 <= zero_s1;

		mag_s3 <= mag_s2;
		k_s3 <= norm_shift(big_s2);
		neg_s3 <= neg_s2;
		zero_s3 <= zero_s2;

		for (int c = 0; c < 3; c++)
			sh_s4[c] <= mag_s3[c] << k_s3;
		neg_s4 <= neg_s3;
		zero_s4 <= zero_s3;

		for (int c = 0; c < 3; c++)
			sq_s5[c] <= 64'(sh_s4[c]) * 64'(sh_s4[c]);
		sh_s5 <= sh_s4;
		neg_s5 <= neg_s4;
		zero_s5 <= zero_s4;

		nn_s[0] <= sq_s5[0] + sq_s5[1] + sq_s5[2];
		rm_s[0] <= '0;
		rt_s[0] <= '0;
		shr_s[0] <= sh_s5;
		negr_s[0] <= neg_s5;
		zr_s[0] <= zero_s5;
	end

	// One root bit per stage: two radicand bits come in from the top of n2.
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
		logic [RW-1:0] rem_in, trial;
		assign rem_in = {rm_s[i][RW-3:0], nn_s[i][63:62]};
		assign trial = RW'({rt_s[i], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vr_s[i+1] <= 1'b0;
			else
				vr_s[i+1] <= vr_s[i];
		end

		always_ff @(posedge clk) begin
			nn_s[i+1] <= {nn_s[i][61:0], 2'b00};
			if (rem_in >= trial) begin
				rm_s[i+1] <= rem_in - trial;
				rt_s[i+1] <= {rt_s[i][ROOT_STEPS-2:0], 1'b1};
			end else begin
				rm_s[i+1] <= rem_in;
				rt_s[i+1] <= {rt_s[i][ROOT_STEPS-2:0], 1'b0};
			end
			shr_s[i+1] <= shr_s[i];
			negr_s[i+1] <= negr_s[i];
			zr_s[i+1] <= zr_s[i];
		end
	end

	// The quotient stays below 2^32, so the numerator's top part starts below the root.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = {shr_s[ROOT_STEPS][c], {(ROOT_STEPS-2){1'b0}}};
			dr_s[0][c] = DW'(num[c][NW-1:32]);
			dl_s[0][c] = num[c][31:0];
			dq_s[0][c] = '0;
		end
		dd_s[0] = rt_s[ROOT_STEPS];
		negd_s[0] = negr_s[ROOT_STEPS];
		zd_s[0] = zr_s[ROOT_STEPS];
		vd_s[0] = vr_s[ROOT_STEPS];
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [DW-1:0] part [3];

		always_comb begin
			for (int c = 0; c < 3; c++)
				part[c] = {dr_s[j][c][DW-2:0], dl_s[j][c][31]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vd_s[j+1] <= 1'b0;
			else
				vd_s[j+1] <= vd_s[j];
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) begin
				dl_s[j+1][c] <= {dl_s[j][c][30:0], 1'b0};
				if (part[c] >= DW'(dd_s[j])) begin
					dr_s[j+1][c] <= part[c] - DW'(dd_s[j]);
					dq_s[j+1][c] <= {dq_s[j][c][30:0], 1'b1};
				end else begin
					dr_s[j+1][c] <= part[c];
					dq_s[j+1][c] <= {dq_s[j][c][30:0], 1'b0};
				end
			end
			dd_s[j+1] <= dd_s[j];
			negd_s[j+1] <= negd_s[j];
			zd_s[j+1] <= zd_s[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (dq_s[DIV_STEPS][c] > 32'(ONE_Q30))
				u_q[c] <= negd_s[DIV_STEPS][c] ? -ONE_Q30 : ONE_Q30;
			else
				u_q[c] <= negd_s[DIV_STEPS][c] ? -$signed(dq_s[DIV_STEPS][c])
					: $signed(dq_s[DIV_STEPS][c]);
		end
		zero_q <= zd_s[DIV_STEPS];
	end

	assign u = u_q;
	assign out_zero = zero_q;
	assign out_valid = valid_q;

endmodule

[src/aar_trig.sv]
module aar_trig import aar_pkg::*; #(
	parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
	input  logic               clk,
	input  logic signed [31:0] angle,
	output logic signed [31:0] sin_v,
	output logic signed [31:0] cos_v
);

	localparam logic [49:0] OFFSET = 50'(TWO_PI_Q32) << (MOD_STEPS - 1);

	logic [49:0] zu_s [MOD_STEPS+1];
	logic signed [36:0] zf_s1;
	logic flip_s1;
	logic signed [33:0] x_s [TRIG_STEPS+1];
	logic signed [33:0] y_s [TRIG_STEPS+1];
	logic signed [36:0] z_s [TRIG_STEPS+1];
	logic flip_s [TRIG_STEPS+1];
	logic signed [31:0] sin_q, cos_q;
	logic signed [36:0] zsym;

	// The offset is a multiple of 2*pi that makes every angle non-negative.
	always_ff @(posedge clk)
		zu_s[0] <= {{2{angle[31]}}, angle, 16'b0} + OFFSET;

	for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
		localparam logic [49:0] SUB = 50'(TWO_PI_Q32) << (MOD_STEPS - 1 - j);
		always_ff @(posedge clk)
			zu_s[j+1] <= (zu_s[j] >= SUB) ? zu_s[j] - SUB : zu_s[j];
	end

	always_comb begin
		if (zu_s[MOD_STEPS] > 50'(PI_Q32))
			zsym = 37'(zu_s[MOD_STEPS]) - 37'(TWO_PI_Q32);
		else
			zsym = 37'(zu_s[MOD_STEPS]);
	end

	// Outside the right half-plane the angle moves by pi and both results change sign.
	always_ff @(posedge clk) begin
		if (zsym > $signed(37'(HALF_PI_Q32))) begin
			zf_s1 <= zsym - 37'(PI_Q32);
			flip_s1 <= 1'b1;
		end else if (zsym < -$signed(37'(HALF_PI_Q32))) begin
			zf_s1 <= zsym + 37'(PI_Q32);
			flip_s1 <= 1'b1;
		end else begin
			zf_s1 <= zsym;
			flip_s1 <= 1'b0;
		end
	end

	assign x_s[0] = CORDIC_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = zf_s1;
	assign flip_s[0] = flip_s1;

	for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cordic
		logic signed [33:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - atan_q32(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + atan_q32(5'(i));
			end
			flip_s[i+1] <= flip_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (flip_s[TRIG_STEPS]) begin
			cos_q <= -clamp_unit(36'(x_s[TRIG_STEPS]));
			sin_q <= -clamp_unit(36'(y_s[TRIG_STEPS]));
		end else begin
			cos_q <= clamp_unit(36'(x_s[TRIG_STEPS]));
			sin_q <= clamp_unit(36'(y_s[TRIG_STEPS]));
		end
	end

	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule

[src/aar_matrix.sv]
module aar_matrix import aar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_zero,
	input  logic signed [31:0] u [3],
	input  logic signed [31:0] sin_v,
	input  logic signed [31:0] cos_v,
	output logic               out_valid,
	output logic               out_zero,
	output logic signed [31:0] m [9]
);

	// Pair order of the outer product: 00, 01, 02, 11, 12, 22.
	logic signed [63:0] uu_p [6];
	logic signed [63:0] us_p [3];
	logic signed [33:0] uu_s1 [6];
	logic signed [33:0] us_s1 [3];
	logic signed [32:0] oc_s1;
	logic signed [31:0] c_s1;
	logic zero_s1, v_s1;
	logic signed [63:0] uo_p [6];
	logic signed [33:0] uo_s2 [6];
	logic signed [33:0] us_s2 [3];
	logic signed [31:0] c_s2;
	logic zero_s2, v_s2;
	logic signed [35:0] sum [9];
	logic signed [31:0] m_s3 [9];
	logic zero_s3, v_s3;

	always_comb begin
		uu_p[0] = u[0] * u[0];
		uu_p[1] = u[0] * u[1];
		uu_p[2] = u[0] * u[2];
		uu_p[3] = u[1] * u[1];
		uu_p[4] = u[1] * u[2];
		uu_p[5] = u[2] * u[2];
		for (int i = 0; i < 3; i++)
			us_p[i] = u[i] * sin_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++)
			uu_s1[i] <= mul_q30(uu_p[i]);
		for (int i = 0; i < 3; i++)
			us_s1[i] <= mul_q30(us_p[i]);
		oc_s1 <= 33'(ONE_Q30) - 33'(cos_v);
		c_s1 <= cos_v;
		zero_s1 <= in_zero;
	end

	always_comb begin
		for (int i = 0; i < 6; i++)
			uo_p[i] = uu_s1[i] * oc_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++)
			uo_s2[i] <= mul_q30(uo_p[i]);
		us_s2 <= us_s1;
		c_s2 <= c_s1;
		zero_s2 <= zero_s1;
	end

	always_comb begin
		sum[0] = 36'(c_s2) + 36'(uo_s2[0]);
		sum[1] = 36'(uo_s2[1]) - 36'(us_s2[2]);
		sum[2] = 36'(uo_s2[2]) + 36'(us_s2[1]);
		sum[3] = 36'(uo_s2[1]) + 36'(us_s2[2]);
		sum[4] = 36'(c_s2) + 36'(uo_s2[3]);
		sum[5] = 36'(uo_s2[4]) - 36'(us_s2[0]);
		sum[6] = 36'(uo_s2[2]) - 36'(us_s2[1]);
		sum[7] = 36'(uo_s2[4]) + 36'(us_s2[0]);
		sum[8] = 36'(c_s2) + 36'(uo_s2[5]);
	end

	// A zero axis has no direction, so the identity is returned.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			if (zero_s2)
				m_s3[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
			else
				m_s3[i] <= clamp_unit(sum[i]);
		end
		zero_s3 <= zero_s2;
	end

	assign m = m_s3;
	assign out_zero = zero_s3;
	assign out_valid = v_s3;

endmodule

[src/axis_angle_to_rotation_matrix_unit.sv]
// Rotation matrix from an axis and an angle (Rodrigues formula), fixed point.
// Request channel: axis_x, axis_y, axis_z and angle (signed Q16.16) are taken
// at a rising edge where start is high and busy is low. busy is never raised,
// so a new request may be issued in every cycle.
// Result channel: done is high for one cycle with m00..m22 (signed Q2.30,
// row-major) and zero_axis. Results leave in request order, one per request.
// The axis path runs through axis scaling and squaring, the square root
// resolved bit by bit, long division for the unit axis, its clamp and the
// matrix products.
// Sine and cosine come from a 14-stage angle reduction and a TRIG_STEPS-stage
// CORDIC running alongside, then wait in a short delay line.
// Throughput is one request per cycle.
// Reset clears only the valid bits of the pipeline; a request in flight is
// dropped. The receiver cannot stall, so nothing is ever held back.
module axis_angle_to_rotation_matrix_unit import aar_pkg::*; #(
	parameter int TRIG_STEPS = TRIG_STEPS_DEF,
	parameter int ROOT_STEPS = ROOT_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic               zero_axis
);

	localparam int ALIGN = norm_latency(ROOT_STEPS) - trig_latency(TRIG_STEPS);
	localparam int LATENCY = norm_latency(ROOT_STEPS) + MATRIX_LATENCY;

	logic accept;
	logic n_valid, n_zero;
	logic signed [31:0] u [3];
	logic signed [31:0] sin_t, cos_t, sin_d, cos_d;
	logic [63:0] sc_d;
	logic signed [31:0] m [9];

	assign busy = 1'b0;
	assign accept = start && !busy;

	aar_norm #(.ROOT_STEPS(ROOT_STEPS)) u_norm (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(n_valid), .out_zero(n_zero), .u(u)
	);

	aar_trig #(.TRIG_STEPS(TRIG_STEPS)) u_trig (
		.clk(clk), .angle(angle), .sin_v(sin_t), .cos_v(cos_t)
	);

	aar_delay #(.W(64), .DEPTH(ALIGN)) u_align (
		.clk(clk), .d({sin_t, cos_t}), .q(sc_d)
	);

	assign sin_d = sc_d[63:32];
	assign cos_d = sc_d[31:0];

	aar_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .in_valid(n_valid), .in_zero(n_zero),
		.u(u), .sin_v(sin_d), .cos_v(cos_d),
		.out_valid(done), .out_zero(zero_axis), .m(m)
	);

	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request did not complete after the pipeline latency");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_axis |-> m00 == ONE_Q30 && m11 == ONE_Q30 && m22 == ONE_Q30
			&& m01 == 0 && m12 == 0 && m20 == 0)
		else $error("zero axis did not give the identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> m00 <= ONE_Q30 && m00 >= -ONE_Q30 && m12 <= ONE_Q30
			&& m12 >= -ONE_Q30 && m21 <= ONE_Q30 && m21 >= -ONE_Q30)
		else $error("matrix entry outside the unit range");

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TRIG_N = 30;
	localparam int ROOT_N = 32;
	localparam int LATENCY = ROOT_N + 42;
	localparam longint CYCLE_LIMIT = 400000;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint TAU_Q32 = 64'sd26986075409;
	localparam longint HALF_TURN_Q32 = 64'sd13493037705;
	localparam longint QUARTER_TURN_Q32 = 64'sd6746518852;

	typedef struct {
		logic signed [31:0] m [9];
		logic zflag;
	} rot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
	logic done;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic zero_axis;

	rot_t pending_mats [$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	longint cycles = 0;

	axis_angle_to_rotation_matrix_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
		.done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
		.m12(m12), .m20(m20), .m21(m21), .m22(m22), .zero_axis(zero_axis)
	);

	always #2 clk = ~clk;

	function automatic longint floor_shift(longint v, int n);
		if (v >= 0)
			return longint'(longint'(unsigned'(v)) >> n);
		return -longint'(longint'(unsigned'(-(v + 1))) >> n) - 1;
	endfunction

	function automatic longint sat_unit(longint v);
		if (v > Q30_ONE)
			return Q30_ONE;
		if (v < -Q30_ONE)
			return -Q30_ONE;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return floor_shift(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic longint arctan_q32(int i);
		longint tab [32] = '{64'sd3373259426, 1991351318, 1052175346, 534100635,
			268086748, 134174063, 67103403, 33553749, 16777131, 8388597,
			4194303, 2097152, 1048576, 524288, 262144, 131072, 65536, 32768,
			16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
		return tab[i];
	endfunction

	task automatic sine_cosine(longint ang, output longint s, output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		z = ang * 65536;
		x = GAIN_Q30;
		y = 0;
		flip = 0;
		z = z % TAU_Q32;
		if (z < 0)
			z += TAU_Q32;
		if (z > HALF_TURN_Q32)
			z -= TAU_Q32;
		if (z > QUARTER_TURN_Q32) begin
			z -= HALF_TURN_Q32;
			flip = 1;
		end else if (z < -QUARTER_TURN_Q32) begin
			z += HALF_TURN_Q32;
			flip = 1;
		end
		for (int i = 0; i < TRIG_N; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_q32(i);
			end else begin
				x += dx;
				y -= dy;
				z += arctan_q32(i);
			end
		end
		x = sat_unit(x);
		y = sat_unit(y);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic rodrigues(input logic signed [31:0] ax, ay, az, ang, output rot_t r);
		longint a [3], u [3], mm [9];
		longint unsigned mag [3], big, n2, root, rem, pair, trial, q;
		longint s, c, oc;
		int k;
		a[0] = ax;
		a[1] = ay;
		a[2] = az;
		for (int i = 0; i < 3; i++)
			mag[i] = a[i] < 0 ? -a[i] : a[i];
		if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
			for (int i = 0; i < 9; i++)
				r.m[i] = (i % 4 == 0) ? 32'(Q30_ONE) : '0;
			r.zflag = 1'b1;
			return;
		end
		big = mag[0];
		if (mag[1] > big)
			big = mag[1];
		if (mag[2] > big)
			big = mag[2];
		k = 0;
		while (k < 31 && (big << k) < (64'd1 << 30))
			k++;
		n2 = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = mag[i] << k;
			n2 += mag[i] * mag[i];
		end
		root = 0;
		rem = 0;
		for (int i = 0; i < ROOT_N; i++) begin
			pair = (i < 32) ? ((n2 >> (62 - 2 * i)) & 3) : 0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else
				root = root << 1;
		end
		for (int i = 0; i < 3; i++) begin
			q = root != 0 ? (mag[i] << (ROOT_N - 2)) / root : 0;
			if (q > Q30_ONE)
				q = Q30_ONE;
			u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
		end
		sine_cosine(longint'(ang), s, c);
		oc = Q30_ONE - c;
		mm[0] = c + qmul(qmul(u[0], u[0]), oc);
		mm[1] = qmul(qmul(u[0], u[1]), oc) - qmul(u[2], s);
		mm[2] = qmul(qmul(u[0], u[2]), oc) + qmul(u[1], s);
		mm[3] = qmul(qmul(u[1], u[0]), oc) + qmul(u[2], s);
		mm[4] = c + qmul(qmul(u[1], u[1]), oc);
		mm[5] = qmul(qmul(u[1], u[2]), oc) - qmul(u[0], s);
		mm[6] = qmul(qmul(u[2], u[0]), oc) - qmul(u[1], s);
		mm[7] = qmul(qmul(u[2], u[1]), oc) + qmul(u[0], s);
		mm[8] = c + qmul(qmul(u[2], u[2]), oc);
		for (int i = 0; i < 9; i++)
			r.m[i] = 32'(sat_unit(mm[i]));
		r.zflag = 1'b0;
	endtask

	// Sends one request, after a random gap only when gaps is set; the gap is
	// skipped sometimes so back-to-back requests also occur.
	task automatic send_request(input logic signed [31:0] ax, ay, az, ang, input bit gaps);
		rot_t r;
		int gap;
		gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		axis_x <= ax;
		axis_y <= ay;
		axis_z <= az;
		angle <= ang;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		rodrigues(ax, ay, az, ang, r);
		pending_mats.push_back(r);
		sent++;
	endtask

	task automatic release_bus();
		start <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		rot_t want;
		logic signed [31:0] got [9];
		cycles++;
		if (arst_n && done) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (pending_mats.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				want = pending_mats.pop_front();
				checked++;
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.m[i]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time,
							i / 3, i % 3, want.m[i], got[i]);
						errors++;
					end
				if (zero_axis !== want.zflag) begin
					$display("%0t: zero_axis expected %0b actual %0b", $time,
						want.zflag, zero_axis);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_extremes();
		logic signed [31:0] v [6] = '{32'sh80000000, 32'sh7fffffff, 32'sh00000001,
			32'shffffffff, 32'sh00010000, 32'sh0};
		send_request(0, 0, 0, 0, 0);
		send_request(0, 0, 0, 32'sh7fffffff, 0);
		send_request(32'sh00010000, 0, 0, 32'sh0001921f, 0);
		send_request(0, 32'sh00010000, 0, 32'sh0003243f, 0);
		send_request(0, 0, 32'sh00010000, -32'sh0003243f, 0);
		send_request(1, 1, 1, 32'sh00019220, 0);
		send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
		send_request(32'sh80000000, 0, 0, 32'sh00064880, 0);
		for (int i = 0; i < 6; i++)
			send_request(v[i], v[(i + 1) % 6], v[(i + 3) % 6], v[(i + 2) % 6], 1);
		send_request(0, 0, 1, 32'sh0000c910, 1);
		send_request(0, 0, 0, 32'sh80000000, 1);
		release_bus();
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			2: return $signed($urandom) >>> $urandom_range(0, 31);
			3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom_range(0, 3) == 0 ? 32'sh0 : $urandom;
		endcase
	endfunction

	task automatic test_random();
		for (int n = 0; n < 1030; n++)
			send_request(rand_word(), rand_word(), rand_word(), rand_word(), n % 100 > 30);
		release_bus();
	endtask

	task automatic drain();
		while (pending_mats.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random();
		drain();
		$display("Sent %0d requests (directed extremes and random axes/angles),", sent);
		$display("checked %0d matrices with random gaps.", checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
